// ===== hdl/tlct_pkg.sv =====
package tlct_pkg;

   // Token kinds on the response channel. Operator tokens use the operator's
   // position in OP_CHARS as their kind.
   localparam logic [4:0] TOK_ASSIGN = 5'd15;
   localparam logic [4:0] TOK_EQUALS = 5'd16;
   localparam logic [4:0] TOK_SYMBOL = 5'd17;
   localparam logic [4:0] TOK_NUMBER = 5'd18;
   localparam logic [4:0] TOK_IF     = 5'd19;
   localparam logic [4:0] TOK_WHILE  = 5'd20;
   localparam logic [4:0] TOK_OUT    = 5'd21;
   localparam logic [4:0] TOK_END    = 5'd22;
   localparam logic [4:0] TOK_ERROR  = 5'd23;

   // Pending token kinds.
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ASSIGN = 2'd1;
   localparam logic [1:0] KIND_SYMBOL = 2'd2;
   localparam logic [1:0] KIND_NUMBER = 2'd3;

   // Character classes found by the front end.
   localparam logic [2:0] CLS_OP     = 3'd0;
   localparam logic [2:0] CLS_EQ     = 3'd1;
   localparam logic [2:0] CLS_LETTER = 3'd2;
   localparam logic [2:0] CLS_DIGIT  = 3'd3;
   localparam logic [2:0] CLS_OTHER  = 3'd4;
   localparam logic [2:0] CLS_END    = 3'd5;

   localparam int NUM_OPS = 15;
   localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
      "+", "-", "*", "/", "%", "<", ">", "!", "&", "|", "(", ")", "{", "}", ";"
   };
   localparam logic [7:0] CHAR_EQ = "=";

   localparam logic [15:0] KW_IF    = "if";
   localparam logic [23:0] KW_OUT   = "out";
   localparam logic [39:0] KW_WHILE = "while";

   // Characters shown in a token's text fields.
   localparam int TEXT_SHOWN = 16;

   // Response queue inside the back end.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTRW  = 2;
   localparam int OUT_CNTW  = 3;

   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] op_idx;
      logic [7:0] ch;
   } item_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [4:0]  length;
      logic [63:0] first;
      logic [63:0] second;
      logic        overflow;
      logic        last;
   } token_type;

endpackage

// ===== hdl/tlct_front.sv =====
module tlct_front
   import tlct_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_input,
   input  logic       queue_full,
   output logic       push,
   output item_type   item
);

   logic       op_found;
   logic [3:0] op_idx;

   // The operator table is searched in parallel; each entry is compared alone.
   always_comb begin
      op_found = 1'b0;
      op_idx   = '0;
      for (int k = NUM_OPS - 1; k >= 0; k--) begin
         if (req_char_in == OP_CHARS[k]) begin
            op_found = 1'b1;
            op_idx   = 4'(k);
         end
      end
   end

   always_comb begin
      item.ch     = req_char_in;
      item.op_idx = op_idx;
      if (req_end_of_input) begin
         item.cls = CLS_END;
      end else if (op_found) begin
         item.cls = CLS_OP;
      end else if (req_char_in == CHAR_EQ) begin
         item.cls = CLS_EQ;
      end else if (req_char_in inside {["a":"z"], ["A":"Z"]}) begin
         item.cls = CLS_LETTER;
      end else if (req_char_in inside {["0":"9"]}) begin
         item.cls = CLS_DIGIT;
      end else begin
         item.cls = CLS_OTHER;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

endmodule

// ===== hdl/tlct_fifo.sv =====
module tlct_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNTW'(DEPTH));
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/tlct_back.sv =====
module tlct_back
   import tlct_pkg::*;
#(
   parameter int MAX_TEXT = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   input  item_type  item,
   output logic      item_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output token_type rsp_token
);

   localparam int LENW = $clog2(MAX_TEXT + 1);

   logic [1:0]      kind_ff, kind_in;
   logic [LENW-1:0] len_ff, len_in;
   logic            ovf_ff, ovf_in;
   logic [7:0]      text_ff [MAX_TEXT];

   token_type         oq_ff [OUT_DEPTH];
   logic [OUT_PTRW-1:0] oq_wr_ff, oq_wr_in;
   logic [OUT_PTRW-1:0] oq_rd_ff, oq_rd_in;
   logic [OUT_CNTW-1:0] oq_cnt_ff, oq_cnt_in;

   logic            take, rsp_pop;
   logic [7:0]      shown_byte [TEXT_SHOWN];
   token_type       text_tok, flush_tok, own_tok, slot0, slot1;
   logic            has_flush, do_flush, own_valid;
   logic            append, kw_if, kw_while, kw_out;
   logic [LENW-1:0] base_len;
   logic            base_ovf;
   logic [1:0]      push_n;

   // Room for two tokens is needed before an item is taken.
   assign take     = item_valid & (oq_cnt_ff <= OUT_CNTW'(OUT_DEPTH - 2));
   assign item_pop = take;

   for (genvar i = 0; i < TEXT_SHOWN; i++) begin : g_show
      if (i < MAX_TEXT) begin : g_held
         assign shown_byte[i] = (32'(len_ff) > i) ? text_ff[i] : 8'h00;
      end else begin : g_none
         assign shown_byte[i] = 8'h00;
      end
   end

   always_comb begin
      text_tok = '0;
      for (int i = 0; i < 8; i++) begin
         text_tok.first[8*i +: 8]  = shown_byte[i];
         text_tok.second[8*i +: 8] = shown_byte[i + 8];
      end
      if (32'(len_ff) > TEXT_SHOWN) begin
         text_tok.length   = 5'(TEXT_SHOWN);
         text_tok.overflow = 1'b1;
      end else begin
         text_tok.length   = 5'(len_ff);
         text_tok.overflow = ovf_ff;
      end
   end

   always_comb begin
      flush_tok = text_tok;
      case (kind_ff)
         KIND_ASSIGN: begin
            flush_tok      = '0;
            flush_tok.kind = TOK_ASSIGN;
         end
         KIND_SYMBOL: flush_tok.kind = TOK_SYMBOL;
         KIND_NUMBER: flush_tok.kind = TOK_NUMBER;
         default:     flush_tok      = '0;
      endcase
   end
   assign has_flush = (kind_ff != KIND_NONE);

   // Eager keyword match: the held text plus the incoming letter spells it.
   assign kw_if = (kind_ff == KIND_SYMBOL) && !ovf_ff && (len_ff == LENW'(1))
      && (text_ff[0] == KW_IF[15:8]) && (item.ch == KW_IF[7:0]);
   assign kw_out = (kind_ff == KIND_SYMBOL) && !ovf_ff && (len_ff == LENW'(2))
      && (text_ff[0] == KW_OUT[23:16]) && (text_ff[1] == KW_OUT[15:8])
      && (item.ch == KW_OUT[7:0]);
   assign kw_while = (kind_ff == KIND_SYMBOL) && !ovf_ff && (len_ff == LENW'(4))
      && (text_ff[0] == KW_WHILE[39:32]) && (text_ff[1] == KW_WHILE[31:24])
      && (text_ff[2] == KW_WHILE[23:16]) && (text_ff[3] == KW_WHILE[15:8])
      && (item.ch == KW_WHILE[7:0]);

   always_comb begin
      do_flush  = 1'b0;
      own_valid = 1'b0;
      own_tok   = '0;
      append    = 1'b0;
      kind_in   = kind_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      case (item.cls)
         CLS_END: begin
            do_flush     = 1'b1;
            own_valid    = 1'b1;
            own_tok.kind = TOK_END;
         end
         CLS_OP: begin
            do_flush     = 1'b1;
            own_valid    = 1'b1;
            own_tok.kind = {1'b0, item.op_idx};
         end
         CLS_EQ: begin
            if (kind_ff == KIND_ASSIGN) begin
               own_valid    = 1'b1;
               own_tok.kind = TOK_EQUALS;
            end else begin
               do_flush = 1'b1;
            end
         end
         CLS_LETTER: begin
            do_flush = (kind_ff != KIND_SYMBOL);
            append   = 1'b1;
            kind_in  = KIND_SYMBOL;
            if (kw_if || kw_while || kw_out) begin
               own_valid    = 1'b1;
               own_tok.kind = kw_if ? TOK_IF : (kw_while ? TOK_WHILE : TOK_OUT);
            end
         end
         CLS_DIGIT: begin
            append = 1'b1;
            if (kind_ff != KIND_NUMBER && kind_ff != KIND_SYMBOL) begin
               do_flush = 1'b1;
               kind_in  = KIND_NUMBER;
            end
         end
         default: begin
            own_valid       = 1'b1;
            own_tok.kind    = TOK_ERROR;
            own_tok.length  = 5'd1;
            own_tok.first   = {56'd0, item.ch};
         end
      endcase

      base_len = do_flush ? '0 : len_ff;
      base_ovf = do_flush ? 1'b0 : ovf_ff;
      if (do_flush) begin
         kind_in = (item.cls == CLS_EQ) ? KIND_ASSIGN : kind_in;
         len_in  = '0;
         ovf_in  = 1'b0;
      end
      if (append) begin
         if (base_len < LENW'(MAX_TEXT)) begin
            len_in = base_len + 1'b1;
            ovf_in = base_ovf;
         end else begin
            len_in = base_len;
            ovf_in = 1'b1;
         end
      end
      // Tokens that end the pending text return the state to none.
      if (item.cls == CLS_END || item.cls == CLS_OP || own_tok.kind == TOK_EQUALS
          || (item.cls == CLS_LETTER && own_valid)) begin
         kind_in = KIND_NONE;
         len_in  = '0;
         ovf_in  = 1'b0;
      end
   end

   always_comb begin
      slot0  = own_tok;
      slot1  = own_tok;
      push_n = 2'd0;
      if (do_flush && has_flush) begin
         slot0  = flush_tok;
         push_n = own_valid ? 2'd2 : 2'd1;
      end else if (own_valid) begin
         push_n = 2'd1;
      end
      slot0.last = (push_n == 2'd1);
      slot1.last = 1'b1;
      if (!take) begin
         push_n = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_NONE;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (take) begin
         kind_ff <= kind_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
      end
   end

   for (genvar j = 0; j < MAX_TEXT; j++) begin : g_text
      always_ff @(posedge clock) begin
         if (take && append && base_len == LENW'(j)) begin
            text_ff[j] <= item.ch;
         end
      end
   end

   assign rsp_valid = (oq_cnt_ff != '0);
   assign rsp_pop   = rsp_valid & ~rsp_stall;
   assign rsp_token = oq_ff[oq_rd_ff];

   always_comb begin
      oq_wr_in  = oq_wr_ff + OUT_PTRW'(push_n);
      oq_rd_in  = oq_rd_ff + OUT_PTRW'(rsp_pop);
      oq_cnt_in = oq_cnt_ff + OUT_CNTW'(push_n) - OUT_CNTW'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         oq_ff[oq_wr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         oq_ff[oq_wr_ff + 1'b1] <= slot1;
      end
   end

endmodule

// ===== hdl/toy_language_char_tokenizer.sv =====
// Channel    Direction  Handshake           Payload
// request    in         req_valid/req_stall  char_in, end_of_input
// response   out        rsp_valid/rsp_stall  token_kind, text_length, text_first,
//                                            text_second, text_overflow, last_of_run
//
// A request is classified in the cycle it is accepted and queued. The back end takes one
// request per cycle, but only while two response slots are free, so requests flow at one
// per cycle while each makes at most one token and the response side does not stall. Two
// tokens from one request leave one after the other through the single response port. A
// token reaches the port through the item queue and the four-token response queue.
// Reset clears the pending token and empties both queues. Either side may stall at any time.
module toy_language_char_tokenizer
   import tlct_pkg::*;
#(
   parameter int MAX_TEXT    = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [4:0]  rsp_text_length,
   output logic [63:0] rsp_text_first,
   output logic [63:0] rsp_text_second,
   output logic        rsp_text_overflow,
   output logic        rsp_last_of_run
);

   item_type  front_item, back_item;
   logic      front_push, queue_full, queue_valid, queue_pop;
   token_type rsp_token;

   // The front end classifies each character: operator, '=', letter, digit,
   // end marker or anything else.
   tlct_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .push             (front_push),
      .item             (front_item)
   );

   // A short queue lets the front end keep taking requests while the back end
   // waits for room in its response queue.
   tlct_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_item),
      .pop       (queue_pop),
      .pop_data  (back_item),
      .not_empty (queue_valid),
      .full      (queue_full)
   );

   // The back end keeps the pending token and its text, flushes it when a
   // new token starts, and matches keywords as soon as they are spelled.
   tlct_back #(
      .MAX_TEXT (MAX_TEXT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (back_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_token  (rsp_token)
   );

   assign rsp_token_kind    = rsp_token.kind;
   assign rsp_text_length   = rsp_token.length;
   assign rsp_text_first    = rsp_token.first;
   assign rsp_text_second   = rsp_token.second;
   assign rsp_text_overflow = rsp_token.overflow;
   assign rsp_last_of_run   = rsp_token.last;

endmodule

// ===== tb/tlct_token_checker.sv =====
module tlct_token_checker
   import tlct_pkg::*;
#(
   parameter int MAX_TEXT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_token_kind,
   input  logic [4:0]  rsp_text_length,
   input  logic [63:0] rsp_text_first,
   input  logic [63:0] rsp_text_second,
   input  logic        rsp_text_overflow,
   input  logic        rsp_last_of_run,
   output int          tokens_outstanding,
   output int          mismatch_count
);

   // Token under construction, mirrored from the block's behavior.
   logic [1:0] held_kind;
   logic [7:0] held_text [MAX_TEXT];
   int         held_len;
   bit         held_ovf;

   token_type  tokens_due [$];
   token_type  step_out [2];
   int         step_n;

   function automatic void clear_held();
      held_kind = KIND_NONE;
      held_len = 0;
      held_ovf = 1'b0;
   endfunction

   function automatic void add_token(input logic [4:0] kind, input logic [4:0] len,
                                     input logic [63:0] first, input logic [63:0] second,
                                     input logic ovf);
      step_out[step_n] = '{kind: kind, length: len, first: first, second: second,
                           overflow: ovf, last: 1'b0};
      step_n++;
   endfunction

   function automatic void add_text_token(input logic [4:0] kind);
      int          len;
      logic        ovf;
      logic [63:0] first;
      logic [63:0] second;
      len = held_len;
      ovf = held_ovf;
      first = '0;
      second = '0;
      if (len > TEXT_SHOWN) begin
         len = TEXT_SHOWN;
         ovf = 1'b1;
      end
      for (int i = 0; i < len && i < MAX_TEXT; i++) begin
         if (i < 8) first[i*8 +: 8] = held_text[i];
         else second[(i-8)*8 +: 8] = held_text[i];
      end
      add_token(kind, 5'(len), first, second, ovf);
   endfunction

   function automatic void flush_held();
      if (held_kind == KIND_ASSIGN) add_token(TOK_ASSIGN, '0, '0, '0, 1'b0);
      else if (held_kind == KIND_SYMBOL) add_text_token(TOK_SYMBOL);
      else if (held_kind == KIND_NUMBER) add_text_token(TOK_NUMBER);
      clear_held();
   endfunction

   function automatic void append_char(input logic [7:0] c);
      if (held_len < MAX_TEXT) begin
         held_text[held_len] = c;
         held_len++;
      end else begin
         held_ovf = 1'b1;
      end
   endfunction

   // Keyword constants hold their first character in the most significant byte.
   function automatic bit spells(input logic [39:0] word, input int wlen);
      if (held_ovf || held_len != wlen) return 1'b0;
      for (int i = 0; i < wlen; i++) begin
         if (held_text[i] != word[(wlen-1-i)*8 +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
      int op;
      op = -1;
      step_n = 0;
      if (eoi) begin
         flush_held();
         add_token(TOK_END, '0, '0, '0, 1'b0);
      end else begin
         for (int k = 0; k < NUM_OPS; k++) begin
            if (op < 0 && OP_CHARS[k] == c) op = k;
         end
         if (op >= 0) begin
            flush_held();
            add_token(5'(op), '0, '0, '0, 1'b0);
         end else if (c == CHAR_EQ) begin
            if (held_kind == KIND_ASSIGN) begin
               add_token(TOK_EQUALS, '0, '0, '0, 1'b0);
               clear_held();
            end else begin
               flush_held();
               held_kind = KIND_ASSIGN;
            end
         end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            if (held_kind != KIND_SYMBOL) flush_held();
            held_kind = KIND_SYMBOL;
            append_char(c);
            if (spells(40'(KW_IF), 2)) begin
               add_token(TOK_IF, '0, '0, '0, 1'b0);
               clear_held();
            end else if (spells(KW_WHILE, 5)) begin
               add_token(TOK_WHILE, '0, '0, '0, 1'b0);
               clear_held();
            end else if (spells(40'(KW_OUT), 3)) begin
               add_token(TOK_OUT, '0, '0, '0, 1'b0);
               clear_held();
            end
         end else if (c >= "0" && c <= "9") begin
            if (held_kind == KIND_NUMBER || held_kind == KIND_SYMBOL) begin
               append_char(c);
            end else begin
               flush_held();
               held_kind = KIND_NUMBER;
               append_char(c);
            end
         end else begin
            add_token(TOK_ERROR, 5'd1, {56'd0, c}, '0, 1'b0);
         end
      end
      if (step_n > 0) step_out[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++) tokens_due = {tokens_due, step_out[i]};
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         clear_held();
         tokens_due.delete();
      end else begin
         if (req_valid && !req_stall) predict_tokens(req_char_in, req_end_of_input);
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               $error("unexpected token: kind %0d, length %0d", rsp_token_kind,
                      rsp_text_length);
               mismatch_count++;
            end else begin
               want = tokens_due.pop_front();
               check_field("token_kind", 64'(want.kind), 64'(rsp_token_kind));
               check_field("text_length", 64'(want.length), 64'(rsp_text_length));
               check_field("text_first", want.first, rsp_text_first);
               check_field("text_second", want.second, rsp_text_second);
               check_field("text_overflow", 64'(want.overflow), 64'(rsp_text_overflow));
               check_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
            end
         end
      end
      tokens_outstanding <= tokens_due.size();
   end

endmodule

// ===== tb/tb_toy_language_char_tokenizer.sv =====
// Top of the tokenizer testbench. It drives the request channel with a
// character stream, randomly stalls the response channel, and leaves all
// prediction and comparison to the checker instance that sits beside the block.
module tb_toy_language_char_tokenizer
   import tlct_pkg::*;
;

   // Number of requests to send in all, the directed opening included.
   localparam int RANDOM_REQUESTS = 1250;
   // Hard stop for a hung block; far above any correct run.
   localparam int CYCLE_LIMIT = 200000;
   // Cycles to keep watching after the last expected token arrived.
   localparam int SETTLE_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'd0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [4:0]  rsp_text_length;
   logic [63:0] rsp_text_first;
   logic [63:0] rsp_text_second;
   logic        rsp_text_overflow;
   logic        rsp_last_of_run;

   int tokens_outstanding;
   int mismatch_count;
   int requests_sent = 0;
   int cycle_count = 0;

   // While quiet is set neither side idles, which gives a long stretch of
   // back-to-back traffic at full rate.
   bit quiet = 1'b0;

   toy_language_char_tokenizer dut (.*);

   tlct_token_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Outside the quiet window the response side stalls in about a quarter of
   // the cycles, independent of whether a token is being offered.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 26);
   end

   // Watchdog: a block that stops accepting requests or loses tokens ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offers one request and returns at the edge where it was accepted. Unless quiet
   // is set, random idle cycles come first, so the valid line drops between requests
   // at random. Each call starts at a rising edge and makes only one assignment to
   // req_valid in that time step.
   task automatic send_request(input logic [7:0] c, input logic eoi);
      if (!quiet) begin
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
   endtask

   // Holds off the sender until every predicted token has come out. The
   // checker publishes its count through a register, hence the first wait.
   task automatic drain_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1) != 0) return 8'("a" + $urandom_range(25));
      return 8'("A" + $urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   // Sends one lexeme of a plausible program, so that symbols, numbers and
   // keywords are built across many requests. A minority of the stream is
   // noise: arbitrary bytes, spaces and end markers at random points.
   task automatic send_random_lexeme();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // Symbol: usually short, sometimes a keyword spelled out, and
         // sometimes longer than the text buffer so characters get dropped.
         n = $urandom_range(9);
         if (n == 0) begin
            case ($urandom_range(2))
               0: send_text("if");
               1: send_text("while");
               default: send_text("out");
            endcase
         end else begin
            n = (n == 1) ? $urandom_range(15, 20) : $urandom_range(1, 6);
            send_request(rand_letter(), 1'b0);
            for (int i = 1; i < n; i++) begin
               send_request(($urandom_range(3) == 0) ? rand_digit() : rand_letter(), 1'b0);
            end
         end
      end else if (pick < 45) begin
         // Number: a short digit run, or a long one that can overflow the buffer.
         n = ($urandom_range(9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 5);
         for (int i = 0; i < n; i++) send_request(rand_digit(), 1'b0);
      end else if (pick < 65) begin
         send_request(OP_CHARS[$urandom_range(NUM_OPS - 1)], 1'b0);
      end else if (pick < 75) begin
         // Either a lone assignment or an equality comparison.
         send_request(CHAR_EQ, 1'b0);
         if ($urandom_range(1) != 0) send_request(CHAR_EQ, 1'b0);
      end else if (pick < 85) begin
         send_request(" ", 1'b0);
      end else if (pick < 93) begin
         send_request(8'($urandom_range(255)), 1'b0);
      end else begin
         // End marker; the character byte is random since the block ignores it.
         send_request(8'($urandom_range(255)), 1'b1);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. The lowest and highest bytes are not part of the
      // language and must come back as errors. Every operator follows, then
      // a keyword, an equality, an assignment flushed by a number, a number
      // flushed by a symbol, and finally an end marker that flushes the symbol.
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b0);
      for (int k = 0; k < NUM_OPS; k++) send_request(OP_CHARS[k], 1'b0);
      send_text("if");
      send_text("==");
      send_text("=9");
      send_request("Z", 1'b0);
      send_request(8'($urandom_range(255)), 1'b1);
      drain_tokens();

      // Random program text. After about one lexeme in three hundred the sender waits for
      // the block to empty completely, and one window runs with no idling on
      // either side.
      while (requests_sent < RANDOM_REQUESTS) begin
         send_random_lexeme();
         if (requests_sent >= 500 && requests_sent < 800) quiet = 1'b1;
         else quiet = 1'b0;
         if ($urandom_range(299) == 0) drain_tokens();
      end
      drain_tokens();

      // The settle window catches any token the block emits beyond prediction.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
